FILE: sv/i2cm_pkg.sv
// Types, codes and segment sequencing shared by the I2C register access core.
`default_nettype none

package i2cm_pkg;

  // Request codes carried in the slave-side tuser
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [9:0] SLOT_TICKS_RESET = 10'd4;

  // Bus segment kinds
  typedef enum logic [3:0] {
    KIND_START,
    KIND_WDEV,
    KIND_WREG,
    KIND_WDATA,
    KIND_WDEV1,
    KIND_ACK,
    KIND_RBYTE,
    KIND_MNACK,
    KIND_STOP
  } kind_t;

  // Transaction engine state
  typedef struct packed {
    logic [4:0] phase;
    logic [2:0] bit_index;
    logic [1:0] sub_step;
    logic [9:0] tick_count;
    logic [7:0] shift_reg;
    logic [7:0] saved_device;
    logic [7:0] saved_register;
    logic [7:0] saved_data;
    logic       is_read;
    logic [7:0] last_read;
    logic       nack_flag;
    logic       scl_level;
    logic       sda_level;
    logic       strobe_level;
  } eng_state_t;

  // One result beat
  typedef struct packed {
    logic [7:0] read_data;
    logic       nack_seen;
    logic       done_res;
    logic       busy_res;
    logic       ack_strobe;
    logic       sda_drive;
    logic       scl_drive;
  } eng_result_t;

  // Segment kind for a phase of a write or read transaction
  function automatic kind_t seg_kind(input logic is_read, input logic [4:0] phase);
    kind_t k;
    k = KIND_STOP;
    if (is_read) begin
      unique case (phase)
        5'd1:    k = KIND_START;
        5'd2:    k = KIND_WDEV;
        5'd3:    k = KIND_ACK;
        5'd4:    k = KIND_WREG;
        5'd5:    k = KIND_ACK;
        5'd6:    k = KIND_START;
        5'd7:    k = KIND_WDEV1;
        5'd8:    k = KIND_ACK;
        5'd9:    k = KIND_RBYTE;
        5'd10:   k = KIND_MNACK;
        default: k = KIND_STOP;
      endcase
    end else begin
      unique case (phase)
        5'd1:    k = KIND_START;
        5'd2:    k = KIND_WDEV;
        5'd3:    k = KIND_ACK;
        5'd4:    k = KIND_WREG;
        5'd5:    k = KIND_ACK;
        5'd6:    k = KIND_WDATA;
        5'd7:    k = KIND_ACK;
        default: k = KIND_STOP;
      endcase
    end
    return k;
  endfunction

  function automatic logic is_wbyte(input kind_t k);
    return (k == KIND_WDEV) || (k == KIND_WREG) || (k == KIND_WDATA) || (k == KIND_WDEV1);
  endfunction

endpackage

`default_nettype wire

FILE: sv/i2c_master_register_access_core.sv
// I2C master single-byte register access core: stream handshake and configuration.
//
// Each slave-side beat is one timing tick of the bus engine. s_tuser carries the
// request (0 tick only, 1 start write, 2 start read); a request is honored only on
// a tick where no transaction is running. s_tdata carries the addresses, the write
// byte and the sampled data line. Every accepted beat produces exactly one
// master-side beat with the pin levels and status after that tick.
// The result is registered and shows on m_tdata the cycle after the tick is
// accepted. One tick is accepted per cycle; the output register is refilled in the
// same cycle it is drained, so throughput is one beat per cycle while m_tready
// stays high. When the receiver stalls, the pending result holds and s_tready
// drops until it is taken.
// cfg_data sets slot_ticks, the ticks held per pin step (0 behaves as 1); write it
// only while the bus is idle. cfg_ready is always high.
// Reset puts the engine idle with both lines released, slot_ticks at 4 and no
// result pending.
`default_nettype none

module i2c_master_register_access_core (
  input  wire         clk,
  input  wire         rst,
  // Tick input
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // device_address, reg_address, write_data, sda_in, zero pad
  input  wire  [1:0]  s_tuser,   // action
  // Result output
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // scl_drive, sda_drive, ack_strobe, busy_res, done_res,
                                 // read_data, nack_seen, zero pad
  // Configuration write
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [9:0]  cfg_data
);

  logic                  accept;
  logic [9:0]            slot_ticks;
  i2cm_pkg::eng_result_t result;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  // Hold the slot length register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ticks <= i2cm_pkg::SLOT_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slot_ticks <= cfg_data;
    end
  end

  i2cm_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .action         (s_tuser),
    .device_address (s_tdata[7:0]),
    .reg_address    (s_tdata[15:8]),
    .write_data     (s_tdata[23:16]),
    .sda_in         (s_tdata[24]),
    .slot_ticks     (slot_ticks),
    .result         (result)
  );

  // Track the output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Load the result register on each accepted tick
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, result.nack_seen, result.read_data, result.done_res,
                  result.busy_res, result.ack_strobe, result.sda_drive, result.scl_drive};
    end
  end

endmodule

`default_nettype wire

FILE: sv/i2cm_engine.sv
// Transaction state register and the per-tick next-state logic of the I2C engine.
`default_nettype none

module i2cm_engine (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  step,
  input  wire  [1:0]           action,
  input  wire  [7:0]           device_address,
  input  wire  [7:0]           reg_address,
  input  wire  [7:0]           write_data,
  input  wire                  sda_in,
  input  wire  [9:0]           slot_ticks,
  output i2cm_pkg::eng_result_t result
);

  i2cm_pkg::eng_state_t state;
  i2cm_pkg::eng_state_t state_next;
  logic                 done_next;

  // Work out one tick: request load, pin step, slot end, segment entry
  always_comb begin
    i2cm_pkg::kind_t k;
    i2cm_pkg::kind_t k_new;
    logic [9:0]      lim;
    logic [9:0]      tick_inc;
    logic [1:0]      last;
    logic            advance;

    state_next = state;
    done_next  = 1'b0;
    advance    = 1'b0;
    k_new      = i2cm_pkg::KIND_STOP;

    if (state.phase == 5'd0 &&
        (action == i2cm_pkg::ACT_WRITE || action == i2cm_pkg::ACT_READ)) begin
      state_next.saved_device   = device_address;
      state_next.saved_register = reg_address;
      state_next.saved_data     = write_data;
      state_next.is_read        = (action == i2cm_pkg::ACT_READ);
      state_next.nack_flag      = 1'b0;
      state_next.phase          = 5'd1;
      state_next.tick_count     = 10'd0;
      state_next.sub_step       = 2'd0;
      state_next.bit_index      = 3'd0;
    end

    k        = i2cm_pkg::seg_kind(state_next.is_read, state_next.phase);
    lim      = (slot_ticks == 10'd0) ? 10'd1 : slot_ticks;
    tick_inc = state_next.tick_count + 10'd1;

    if (k == i2cm_pkg::KIND_START)      last = 2'd3;
    else if (k == i2cm_pkg::KIND_RBYTE) last = 2'd1;
    else                                last = 2'd2;

    if (state_next.phase != 5'd0) begin
      // Apply the pin change on the first tick of a slot
      if (state_next.tick_count == 10'd0) begin
        state_next.strobe_level = 1'b1;
        if (k == i2cm_pkg::KIND_START) begin
          unique case (state_next.sub_step)
            2'd0:    state_next.sda_level = 1'b1;
            2'd1:    state_next.scl_level = 1'b1;
            2'd2:    state_next.sda_level = 1'b0;
            default: state_next.scl_level = 1'b0;
          endcase
        end else if (i2cm_pkg::is_wbyte(k)) begin
          if (state_next.sub_step == 2'd0)      state_next.sda_level = state_next.shift_reg[7];
          else if (state_next.sub_step == 2'd1) state_next.scl_level = 1'b1;
          else                                  state_next.scl_level = 1'b0;
        end else if (k == i2cm_pkg::KIND_ACK || k == i2cm_pkg::KIND_MNACK) begin
          if (k == i2cm_pkg::KIND_ACK && !state_next.is_read) state_next.strobe_level = 1'b0;
          if (state_next.sub_step == 2'd0)      state_next.sda_level = 1'b1;
          else if (state_next.sub_step == 2'd1) state_next.scl_level = 1'b1;
          else                                  state_next.scl_level = 1'b0;
        end else if (k == i2cm_pkg::KIND_RBYTE) begin
          state_next.scl_level = (state_next.sub_step == 2'd0);
        end else begin
          if (state_next.sub_step == 2'd0)      state_next.sda_level = 1'b0;
          else if (state_next.sub_step == 2'd1) state_next.scl_level = 1'b1;
          else                                  state_next.sda_level = 1'b1;
        end
      end

      // Count ticks and close the slot, sampling on its last tick
      if (tick_inc >= lim) begin
        state_next.tick_count = 10'd0;
        if (k == i2cm_pkg::KIND_ACK && state_next.sub_step == 2'd1 && sda_in) begin
          state_next.nack_flag = 1'b1;
        end
        if (k == i2cm_pkg::KIND_RBYTE && state_next.sub_step == 2'd0) begin
          state_next.shift_reg = {state_next.shift_reg[6:0], sda_in};
        end
        if (state_next.sub_step < last) begin
          state_next.sub_step = state_next.sub_step + 2'd1;
        end else begin
          state_next.sub_step = 2'd0;
          advance = 1'b1;
          if (i2cm_pkg::is_wbyte(k) || k == i2cm_pkg::KIND_RBYTE) begin
            if (i2cm_pkg::is_wbyte(k)) state_next.shift_reg = {state_next.shift_reg[6:0], 1'b0};
            if (state_next.bit_index < 3'd7) begin
              state_next.bit_index = state_next.bit_index + 3'd1;
              advance = 1'b0;
            end else begin
              state_next.bit_index = 3'd0;
              if (k == i2cm_pkg::KIND_RBYTE) state_next.last_read = state_next.shift_reg;
            end
          end
        end

        // Move to the next segment, or finish after stop
        if (advance) begin
          if (k == i2cm_pkg::KIND_STOP) begin
            state_next.phase = 5'd0;
            done_next        = 1'b1;
          end else begin
            state_next.phase     = state_next.phase + 5'd1;
            k_new                = i2cm_pkg::seg_kind(state_next.is_read, state_next.phase);
            state_next.sub_step  = 2'd0;
            state_next.bit_index = 3'd0;
            unique case (k_new)
              i2cm_pkg::KIND_WDEV:  state_next.shift_reg = state_next.saved_device;
              i2cm_pkg::KIND_WREG:  state_next.shift_reg = state_next.saved_register;
              i2cm_pkg::KIND_WDATA: state_next.shift_reg = state_next.saved_data;
              i2cm_pkg::KIND_WDEV1: state_next.shift_reg = state_next.saved_device + 8'd1;
              i2cm_pkg::KIND_RBYTE: state_next.shift_reg = 8'd0;
              default:              state_next.shift_reg = state_next.shift_reg;
            endcase
          end
        end
      end else begin
        state_next.tick_count = tick_inc;
      end
    end else begin
      state_next.strobe_level = 1'b1;
    end
  end

  // Hold state between beats, advance on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2cm_pkg::eng_state_t'{scl_level: 1'b1, sda_level: 1'b1, strobe_level: 1'b1,
                                      default: '0};
    end else if (step) begin
      state <= state_next;
    end
  end

  // Result of this tick, taken from the updated state
  assign result.scl_drive  = state_next.scl_level;
  assign result.sda_drive  = state_next.sda_level;
  assign result.ack_strobe = state_next.strobe_level;
  assign result.busy_res   = (state_next.phase != 5'd0);
  assign result.done_res   = done_next;
  assign result.read_data  = state_next.last_read;
  assign result.nack_seen  = state_next.nack_flag;

endmodule

`default_nettype wire
